FILE: rtl/sact_pkg.sv
// Package for the servo angle calibration table: widths, codes, table types and helpers.
`timescale 1ns / 1ps
package sact_pkg;

    // Field widths fixed by the command and result words
    localparam int CMD_W  = 2;
    localparam int ID_W   = 4;
    localparam int PWM_W  = 8;
    localparam int ANG_W  = 16;
    localparam int MAG_W  = 16;            // magnitude of an angle difference
    localparam int PROD_W = MAG_W + PWM_W; // magnitude of the interpolation product

    // Serial unit step counts
    localparam int MUL_STEPS = PWM_W;
    localparam int DIV_STEPS = PROD_W;

    // Table size
    localparam int SERVO_COUNT_DEF = 12;
    localparam int TABLE_SLOTS     = 16;

    // Default pwm per servo after reset; slots past the last servo read zero
    localparam logic [PWM_W-1:0] DEFAULT_PWM_RESET [TABLE_SLOTS] = '{
        8'd44, 8'd73, 8'd30, 8'd112, 8'd81, 8'd38, 8'd50, 8'd100,
        8'd130, 8'd105, 8'd74, 8'd32, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_PWM   = 2'd0,
        CMD_SET_ANGLE = 2'd1,
        CMD_WRITE_CAL = 2'd2,
        CMD_READ_CAL  = 2'd3
    } t_cmd;

    // Result word kinds
    localparam logic RESP_ACK    = 1'b0;
    localparam logic RESP_REPORT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_REPORT,
        S_ACK
    } t_state;

    // One calibration entry
    typedef struct packed {
        logic [PWM_W-1:0] base_pwm;
        logic [ANG_W-1:0] angle_a;
        logic [PWM_W-1:0] pwm_a;
        logic [ANG_W-1:0] angle_b;
        logic [PWM_W-1:0] pwm_b;
    } t_entry;

    // Table write port
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] idx;
        t_entry          data;
    } t_tab_wr;

    // Serial multiplier request and response
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mcand;
        logic [PWM_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } t_mul_rsp;

    // Serial divider request and response
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [MAG_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
    } t_div_rsp;

    // Magnitude of a 17-bit two's complement angle difference
    function automatic logic [MAG_W-1:0] mag_angle(input logic [MAG_W:0] v);
        logic [MAG_W:0] neg;
        neg = -v;
        return v[MAG_W] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // Magnitude of a 9-bit two's complement pwm difference
    function automatic logic [PWM_W-1:0] mag_pwm(input logic [PWM_W:0] v);
        logic [PWM_W:0] neg;
        neg = -v;
        return v[PWM_W] ? neg[PWM_W-1:0] : v[PWM_W-1:0];
    endfunction

endpackage

FILE: rtl/sact_table.sv
// Calibration table: one entry per servo, one write and one registered read port.
`timescale 1ns / 1ps
module sact_table #(
    parameter int SERVO_COUNT = sact_pkg::SERVO_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sact_pkg::t_tab_wr         i_wr,
    input  logic                      i_rd_en,
    input  logic [sact_pkg::ID_W-1:0] i_rd_idx,
    output sact_pkg::t_entry          o_rd
);
    import sact_pkg::*;

    localparam int IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

    t_entry r_tab [SERVO_COUNT];
    t_entry r_rd;

    // Entry storage, reset to the per-servo defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_tab[i] <= '{base_pwm: DEFAULT_PWM_RESET[i], angle_a: '0,
                              pwm_a: '0, angle_b: '0, pwm_b: '0};
            end
        end else if (i_wr.en) begin
            r_tab[i_wr.idx[IW-1:0]] <= i_wr.data;
        end
    end

    // Registered read, captured when a command word is taken
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_tab[i_rd_idx[IW-1:0]];
        end
    end

    assign o_rd = r_rd;

endmodule

FILE: rtl/sact_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps
module sact_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sact_pkg::t_mul_req i_req,
    output sact_pkg::t_mul_rsp o_rsp
);
    import sact_pkg::*;

    localparam int CW = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
    localparam logic [CW-1:0] LAST = CW'(MUL_STEPS - 1);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mc;
    logic [PWM_W-1:0]  r_mr;

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add datapath: add the shifted multiplicand where the multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_mc  <= {{(PROD_W-MAG_W){1'b0}}, i_req.mcand};
            r_mr  <= i_req.mplier;
        end else if (r_run) begin
            if (r_mr[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[PROD_W-2:0], 1'b0};
            r_mr <= {1'b0, r_mr[PWM_W-1:1]};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

FILE: rtl/sact_div.sv
// Restoring divider, unsigned: one quotient bit per cycle.
`timescale 1ns / 1ps
module sact_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sact_pkg::t_div_req i_req,
    output sact_pkg::t_div_rsp o_rsp
);
    import sact_pkg::*;

    localparam int CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam logic [CW-1:0] LAST = CW'(DIV_STEPS - 1);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [MAG_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_q;
    logic [MAG_W-1:0]  r_d;

    logic [MAG_W:0]    rem_sh;
    logic [MAG_W+1:0]  trial;
    logic              fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        rem_sh = {r_rem, r_q[PROD_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_d};
        fits   = !trial[MAG_W+1];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out of the top of r_q while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_d   <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= fits ? trial[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            r_q   <= {r_q[PROD_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: rtl/servo_angle_calibration_table_top.sv
// Top level of the servo angle calibration table: command sequencer and result words.
//
//  channel   | direction | handshake                         | payload
//  ----------+-----------+-----------------------------------+---------------------------------
//  command   | in        | taken at i_start high, o_busy low | i_cmd, i_servo_id, pwm/angle fields
//  result    | out       | o_strobe high for one cycle       | o_response_kind ... o_last_of_run
//
// Set pwm, write calibration, read of an unknown servo and set angle on an unknown
// servo or with equal calibration angles: the ack follows in S_ACK after S_SETUP.
// Read calibration: the report in S_REPORT after S_SETUP, then the ack. Set angle with
// distinct angles: the ack after S_MUL, on the bit-serial multiplier (8 steps), and
// S_DIV, on the restoring divider (24 steps). o_busy stays high up to and including
// the ack cycle; reset restores the table defaults at once. The receiver cannot stall.
`timescale 1ns / 1ps
module servo_angle_calibration_table_top #(
    parameter int SERVO_COUNT = sact_pkg::SERVO_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [sact_pkg::CMD_W-1:0]        i_cmd,
    input  logic [sact_pkg::ID_W-1:0]         i_servo_id,
    input  logic [sact_pkg::PWM_W-1:0]        i_direct_pwm,
    input  logic signed [sact_pkg::ANG_W-1:0] i_target_angle,
    input  logic [sact_pkg::PWM_W-1:0]        i_new_default_pwm,
    input  logic signed [sact_pkg::ANG_W-1:0] i_new_angle_a,
    input  logic [sact_pkg::PWM_W-1:0]        i_new_pwm_a,
    input  logic signed [sact_pkg::ANG_W-1:0] i_new_angle_b,
    input  logic [sact_pkg::PWM_W-1:0]        i_new_pwm_b,
    output logic                              o_strobe,
    output logic                              o_response_kind,
    output logic [sact_pkg::CMD_W-1:0]        o_echo_cmd,
    output logic                              o_drive_valid,
    output logic [sact_pkg::ID_W-1:0]         o_drive_servo,
    output logic [sact_pkg::PWM_W-1:0]        o_drive_pwm,
    output logic [sact_pkg::ID_W-1:0]         o_report_servo,
    output logic [sact_pkg::PWM_W-1:0]        o_report_default_pwm,
    output logic signed [sact_pkg::ANG_W-1:0] o_report_angle_a,
    output logic [sact_pkg::PWM_W-1:0]        o_report_pwm_a,
    output logic signed [sact_pkg::ANG_W-1:0] o_report_angle_b,
    output logic [sact_pkg::PWM_W-1:0]        o_report_pwm_b,
    output logic                              o_last_of_run
);
    import sact_pkg::*;

    localparam int SUM_W = PROD_W + 2;

    // Sequencer and command registers
    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ID_W-1:0]   r_id, n_id;
    logic              r_known, n_known;
    logic [PWM_W-1:0]  r_direct, n_direct;
    logic [ANG_W-1:0]  r_angle, n_angle;
    logic              r_drive_valid, n_drive_valid;
    logic [PWM_W-1:0]  r_pwm, n_pwm;

    logic              busy;
    logic              accept;
    logic              known_in;
    t_tab_wr           tab_wr;
    logic [ID_W-1:0]   rd_idx;
    t_entry            ent;
    t_mul_req          mul_req;
    t_mul_rsp          mul_rsp;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [MAG_W:0]    diff_x;
    logic [MAG_W:0]    diff_d;
    logic [PWM_W:0]    diff_p;
    logic              quot_neg;
    logic [SUM_W-1:0]  q_ext;
    logic [SUM_W-1:0]  q_signed;
    logic [SUM_W-1:0]  sum;
    logic [PWM_W-1:0]  clamped;

    // Command word intake
    assign busy     = (r_state != S_IDLE);
    assign accept   = i_start && !busy;
    assign known_in = ({1'b0, i_servo_id} < (ID_W+1)'(SERVO_COUNT));
    assign rd_idx   = known_in ? i_servo_id : '0;

    // Calibration write goes straight into the table on the taking edge
    always_comb begin
        tab_wr.en            = accept && (t_cmd'(i_cmd) == CMD_WRITE_CAL) && known_in;
        tab_wr.idx           = i_servo_id;
        tab_wr.data.base_pwm = i_new_default_pwm;
        tab_wr.data.angle_a  = i_new_angle_a;
        tab_wr.data.pwm_a    = i_new_pwm_a;
        tab_wr.data.angle_b  = i_new_angle_b;
        tab_wr.data.pwm_b    = i_new_pwm_b;
    end

    sact_table #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tab_wr),
        .i_rd_en  (accept),
        .i_rd_idx (rd_idx),
        .o_rd     (ent)
    );

    sact_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    sact_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Interpolation operands; the entry read holds still for the whole command
    always_comb begin
        diff_x   = {r_angle[ANG_W-1], r_angle} - {ent.angle_a[ANG_W-1], ent.angle_a};
        diff_d   = {ent.angle_b[ANG_W-1], ent.angle_b} - {ent.angle_a[ANG_W-1], ent.angle_a};
        diff_p   = {1'b0, ent.pwm_b} - {1'b0, ent.pwm_a};
        quot_neg = diff_x[MAG_W] ^ diff_p[PWM_W] ^ diff_d[MAG_W];
    end

    // Signed quotient (truncated toward zero) plus pwm_a, saturated to the pwm range
    always_comb begin
        q_ext    = {2'b00, div_rsp.quot};
        q_signed = quot_neg ? -q_ext : q_ext;
        sum      = q_signed + {{(SUM_W-PWM_W){1'b0}}, ent.pwm_a};
        if (sum[SUM_W-1]) begin
            clamped = '0;
        end else if (|sum[SUM_W-2:PWM_W]) begin
            clamped = '1;
        end else begin
            clamped = sum[PWM_W-1:0];
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command payload registers
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_id          <= n_id;
        r_known       <= n_known;
        r_direct      <= n_direct;
        r_angle       <= n_angle;
        r_drive_valid <= n_drive_valid;
        r_pwm         <= n_pwm;
    end

    // Next state, unit requests and result word
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_id          = r_id;
        n_known       = r_known;
        n_direct      = r_direct;
        n_angle       = r_angle;
        n_drive_valid = r_drive_valid;
        n_pwm         = r_pwm;

        mul_req.start  = 1'b0;
        mul_req.mcand  = mag_angle(diff_x);
        mul_req.mplier = mag_pwm(diff_p);
        div_req.start    = 1'b0;
        div_req.dividend = mul_rsp.product;
        div_req.divisor  = mag_angle(diff_d);

        o_strobe             = 1'b0;
        o_response_kind      = RESP_ACK;
        o_echo_cmd           = r_cmd;
        o_drive_valid        = 1'b0;
        o_drive_servo        = '0;
        o_drive_pwm          = '0;
        o_report_servo       = '0;
        o_report_default_pwm = '0;
        o_report_angle_a     = '0;
        o_report_pwm_a       = '0;
        o_report_angle_b     = '0;
        o_report_pwm_b       = '0;
        o_last_of_run        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd         = t_cmd'(i_cmd);
                    n_id          = i_servo_id;
                    n_known       = known_in;
                    n_direct      = i_direct_pwm;
                    n_angle       = i_target_angle;
                    n_drive_valid = 1'b0;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state       = S_ACK;
                n_drive_valid = 1'b0;
                unique case (r_cmd)
                    CMD_SET_PWM: begin
                        n_drive_valid = r_known;
                        n_pwm         = r_direct;
                    end
                    CMD_SET_ANGLE: begin
                        n_drive_valid = r_known;
                        if (r_known) begin
                            if (ent.angle_a == ent.angle_b) begin
                                n_pwm = ent.base_pwm;
                            end else begin
                                mul_req.start = 1'b1;
                                n_state       = S_MUL;
                            end
                        end
                    end
                    CMD_WRITE_CAL: begin
                        n_state = S_ACK;
                    end
                    CMD_READ_CAL: begin
                        n_state = r_known ? S_REPORT : S_ACK;
                    end
                    default: begin
                        n_state = S_ACK;
                    end
                endcase
            end
            S_MUL: begin
                if (mul_rsp.done) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_pwm   = clamped;
                    n_state = S_ACK;
                end
            end
            S_REPORT: begin
                o_strobe             = 1'b1;
                o_response_kind      = RESP_REPORT;
                o_report_servo       = r_id;
                o_report_default_pwm = ent.base_pwm;
                o_report_angle_a     = ent.angle_a;
                o_report_pwm_a       = ent.pwm_a;
                o_report_angle_b     = ent.angle_b;
                o_report_pwm_b       = ent.pwm_b;
                n_state              = S_ACK;
            end
            S_ACK: begin
                o_strobe      = 1'b1;
                o_drive_valid = r_drive_valid;
                o_drive_servo = r_drive_valid ? r_id : '0;
                o_drive_pwm   = r_drive_valid ? r_pwm : '0;
                o_last_of_run = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = busy;

    // Checks on sequencing
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result word shown while idle");

    a_report_then_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_response_kind == RESP_REPORT)) |=>
        (o_strobe && (o_response_kind == RESP_ACK) && o_last_of_run))
        else $error("report not followed by its ack");

    a_drive_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drive_valid |-> (o_strobe && (o_response_kind == RESP_ACK)))
        else $error("drive outside an ack");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside its state");

endmodule
